// ===== rtl/ieh_pkg.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Interval event histogram package
// Shared sizes, item kind codes and register indexes.
// -----------------------------------------------------------------------------
package ieh_pkg;

   localparam int NUM_TYPES   = 64;
   localparam int TYPE_W      = 6;
   localparam int COUNT_WIDTH = 32;
   localparam int MASK_W      = 64;
   localparam int TICK_W      = 16;
   localparam int FUNC_W      = 2;
   localparam int CSR_ADDR_W  = 1;
   localparam int CSR_DATA_W  = 64;
   localparam int REQ_DATA_W  = 8;
   localparam int RSP_DATA_W  = 40;

   typedef logic [COUNT_WIDTH-1:0] count_type;
   typedef logic [TYPE_W-1:0]      type_idx_type;

   localparam logic [FUNC_W-1:0] FUNC_EVENT = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_FLUSH = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_NONE  = 2'd3;

   localparam logic [CSR_ADDR_W-1:0] REG_TYPE_MASK = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_TICKS     = 1'd1;

   localparam count_type CNT_MAX = '1;

endpackage

// ===== rtl/interval_event_histogram.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Interval event histogram
// Counts typed events per interval in a counter RAM and dumps enabled counts.
// -----------------------------------------------------------------------------
// Event and tick items: one per cycle while idle; a counter is read when an
// event is accepted and written back by the update stage, with forwarding
// between back-to-back hits. Dump: disabled types are skipped, enabled ones are
// read and then loaded into the output register (which may stall); the walk waits
// first for a pending event write-back; input waits meanwhile.
// Reset (synchronous): counters read as zero via per-entry valid bits, tick count
// and mask zero, interval one.
module interval_event_histogram (
   input  logic                           clock,
   input  logic                           reset,
   // request stream
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [ieh_pkg::REQ_DATA_W-1:0] req_tdata,  // [5:0] event_type, [7:6] zero
   input  logic [ieh_pkg::FUNC_W-1:0]     req_tuser,  // [1:0] func
   // response stream
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [ieh_pkg::RSP_DATA_W-1:0] rsp_tdata,  // [5:0] type_index,
                                                      // [37:6] type_count, [39:38] zero
   output logic                           rsp_tlast,
   // configuration writes
   input  logic                           csr_we,
   input  logic [ieh_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [ieh_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam logic [1:0] ST_IDLE    = 2'd0;
   localparam logic [1:0] ST_DUMP_RD = 2'd1;
   localparam logic [1:0] ST_DUMP_LD = 2'd2;

   // configuration registers
   logic [ieh_pkg::MASK_W-1:0] mask_ff;
   logic [ieh_pkg::TICK_W-1:0] ticks_ff;

   // counter RAM with per-entry valid bits (invalid entry reads as zero)
   ieh_pkg::count_type         cnt_mem [ieh_pkg::NUM_TYPES];
   ieh_pkg::count_type         rd_data_ff;
   logic [ieh_pkg::NUM_TYPES-1:0] cnt_vld_ff, cnt_vld_in;

   // control
   logic [1:0]                 state_ff, state_in;
   ieh_pkg::type_idx_type      idx_ff, idx_in;
   logic [ieh_pkg::TICK_W-1:0] tick_ff, tick_in;

   // event update stage
   logic                       ev_vld_ff;
   ieh_pkg::type_idx_type      ev_addr_ff;
   logic                       ev_rdv_ff;
   logic                       wr_vld_ff;
   ieh_pkg::type_idx_type      wr_addr_ff;
   ieh_pkg::count_type         wr_data_ff;

   // output register
   logic                       rsp_vld_ff, rsp_vld_in;
   ieh_pkg::type_idx_type      rsp_idx_ff;
   ieh_pkg::count_type         rsp_cnt_ff;
   logic                       rsp_last_ff;

   logic                       req_acc;
   logic [ieh_pkg::FUNC_W-1:0] func;
   ieh_pkg::type_idx_type      evt;
   logic                       ev_take;
   logic [ieh_pkg::TICK_W-1:0] tick_inc;
   logic                       dump_go;
   logic                       rd_en;
   ieh_pkg::type_idx_type      rd_addr;
   ieh_pkg::count_type         ev_cur;
   ieh_pkg::count_type         ev_new;
   logic                       wr_en;
   logic [ieh_pkg::MASK_W-1:0] mask_hi;
   logic                       dump_last;
   logic                       rsp_load;
   ieh_pkg::count_type         dump_cnt;

   assign func       = req_tuser;
   assign evt        = req_tdata[ieh_pkg::TYPE_W-1:0];
   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;

   // an event counts only if its type is in range and enabled
   assign ev_take = req_acc && (func == ieh_pkg::FUNC_EVENT) && mask_ff[evt]
                    && ({1'b0, evt} < 7'(ieh_pkg::NUM_TYPES));

   assign tick_inc = tick_ff + 1'b1;

   // interval boundary or flush; an empty mask dump emits nothing
   always_comb begin
      dump_go = 1'b0;
      tick_in = tick_ff;
      if (req_acc) begin
         case (func)
            ieh_pkg::FUNC_TICK: begin
               if (tick_inc == ticks_ff) begin
                  tick_in = '0;
                  dump_go = (mask_ff[ieh_pkg::NUM_TYPES-1:0] != '0);
               end else begin
                  tick_in = tick_inc;
               end
            end
            ieh_pkg::FUNC_FLUSH: dump_go = (mask_ff[ieh_pkg::NUM_TYPES-1:0] != '0);
            default: ;
         endcase
      end
   end

   // RAM read port: event lookup when idle, counter walk while dumping
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = evt;
      if (state_ff == ST_DUMP_RD) begin
         rd_addr = idx_ff;
         rd_en   = mask_ff[idx_ff] && !ev_vld_ff;
      end else if (ev_take) begin
         rd_en = 1'b1;
      end
   end

   // read-modify-write: forward the previous write when it hits the same entry
   always_comb begin
      if (wr_vld_ff && (wr_addr_ff == ev_addr_ff))
         ev_cur = wr_data_ff;
      else if (ev_rdv_ff)
         ev_cur = rd_data_ff;
      else
         ev_cur = '0;
      ev_new = (ev_cur == ieh_pkg::CNT_MAX) ? ev_cur : ev_cur + 1'b1;
   end
   assign wr_en = ev_vld_ff;

   // dump walk: last result when no enabled type lies above the current one
   assign mask_hi   = mask_ff >> idx_ff;
   assign dump_last = (mask_hi[ieh_pkg::MASK_W-1:1] == '0) ||
                      (idx_ff == ieh_pkg::type_idx_type'(ieh_pkg::NUM_TYPES - 1));
   assign dump_cnt  = cnt_vld_ff[idx_ff] ? rd_data_ff : '0;
   assign rsp_load  = (state_ff == ST_DUMP_LD) && (!rsp_vld_ff || rsp_tready);

   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      cnt_vld_in = cnt_vld_ff;
      if (wr_en)
         cnt_vld_in[ev_addr_ff] = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            if (dump_go) begin
               state_in = ST_DUMP_RD;
               idx_in   = '0;
            end
         end
         ST_DUMP_RD: begin
            // hold while the last event's write-back is still pending, then
            // skip disabled types and fetch enabled ones
            if (!ev_vld_ff) begin
               if (mask_ff[idx_ff])
                  state_in = ST_DUMP_LD;
               else
                  idx_in = idx_ff + 1'b1;
            end
         end
         ST_DUMP_LD: begin
            // hold the fetched count until the output register is free
            if (rsp_load) begin
               cnt_vld_in[idx_ff] = 1'b0;
               if (dump_last) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_DUMP_RD;
                  idx_in   = idx_ff + 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_vld_in = rsp_vld_ff;
      if (rsp_load)
         rsp_vld_in = 1'b1;
      else if (rsp_tready)
         rsp_vld_in = 1'b0;
   end

   // counter RAM
   always_ff @(posedge clock) begin
      if (wr_en)
         cnt_mem[ev_addr_ff] <= ev_new;
      if (rd_en)
         rd_data_ff <= cnt_mem[rd_addr];
   end

   // payload registers
   always_ff @(posedge clock) begin
      ev_addr_ff <= evt;
      ev_rdv_ff  <= cnt_vld_ff[evt];
      wr_addr_ff <= ev_addr_ff;
      wr_data_ff <= ev_new;
      if (rsp_load) begin
         rsp_idx_ff  <= idx_ff;
         rsp_cnt_ff  <= dump_cnt;
         rsp_last_ff <= dump_last;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         idx_ff     <= '0;
         tick_ff    <= '0;
         cnt_vld_ff <= '0;
         ev_vld_ff  <= 1'b0;
         wr_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
         mask_ff    <= '0;
         ticks_ff   <= ieh_pkg::TICK_W'(1);
      end else begin
         state_ff   <= state_in;
         idx_ff     <= idx_in;
         tick_ff    <= tick_in;
         cnt_vld_ff <= cnt_vld_in;
         ev_vld_ff  <= ev_take;
         wr_vld_ff  <= wr_en;
         rsp_vld_ff <= rsp_vld_in;
         if (csr_we) begin
            case (csr_addr)
               ieh_pkg::REG_TYPE_MASK: mask_ff  <= csr_wdata;
               ieh_pkg::REG_TICKS:     ticks_ff <= csr_wdata[ieh_pkg::TICK_W-1:0];
               default: ;
            endcase
         end
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {2'b00, rsp_cnt_ff, rsp_idx_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule
